### hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the I-type execute block.
// No dependencies; every user must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, sampled on clk, off while in reset.
`define ITE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen on a clock edge.
`define ITE_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### hw/rtl/ite_pkg.sv
// Shared types and constants for the I-type execute block.
// No dependencies.
package ite_pkg;

    localparam int WORD_W = 32;
    localparam int HALF_W = 16;
    localparam int OP_W   = 5;
    localparam int LANE_W = 4;

    localparam logic [WORD_W-1:0] FULL_MASK  = 32'hFFFF_FFFF;
    localparam int                HALF_SHIFT = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ADDI   = 5'd0,
        OP_ADDIU  = 5'd1,
        OP_ANDI   = 5'd2,
        OP_ORI    = 5'd3,
        OP_XORI   = 5'd4,
        OP_SLTI   = 5'd5,
        OP_SLTIU  = 5'd6,
        OP_LUI    = 5'd7,
        OP_LW     = 5'd8,
        OP_LB     = 5'd9,
        OP_LBU    = 5'd10,
        OP_LH     = 5'd11,
        OP_LHU    = 5'd12,
        OP_LWL    = 5'd13,
        OP_LWR    = 5'd14,
        OP_SW     = 5'd15,
        OP_SB     = 5'd16,
        OP_SH     = 5'd17,
        OP_BEQ    = 5'd18,
        OP_BNE    = 5'd19,
        OP_BGEZ   = 5'd20,
        OP_BGTZ   = 5'd21,
        OP_BLEZ   = 5'd22,
        OP_BLTZ   = 5'd23,
        OP_BGEZAL = 5'd24,
        OP_BLTZAL = 5'd25
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [WORD_W-1:0] base_value;
        logic [WORD_W-1:0] target_value;
        logic [HALF_W-1:0] immediate;
        logic [WORD_W-1:0] memory_word;
    } instr_t;

    typedef struct packed {
        logic              write_enable;
        logic [WORD_W-1:0] write_value;
        logic [WORD_W-1:0] effective_address;
        logic              read_enable;
        logic              store_enable;
        logic [LANE_W-1:0] byte_lanes;
        logic [WORD_W-1:0] store_word;
        logic              branch_taken;
        logic              link_request;
        logic              overflow;
        logic              address_error;
    } result_t;

endpackage

### hw/rtl/ite_if.sv
// Request and result channel interfaces for the I-type execute block.
// Depends on ite_pkg for field widths.
interface ite_instr_if;
    import ite_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [WORD_W-1:0] base_value;
    logic [WORD_W-1:0] target_value;
    logic [HALF_W-1:0] immediate;
    logic [WORD_W-1:0] memory_word;

    modport source (output valid, operation, base_value, target_value, immediate,
                    memory_word, input ready);
    modport sink   (input valid, operation, base_value, target_value, immediate,
                    memory_word, output ready);
endinterface

interface ite_result_if;
    import ite_pkg::*;

    logic              valid;
    logic              ready;
    logic              write_enable;
    logic [WORD_W-1:0] write_value;
    logic [WORD_W-1:0] effective_address;
    logic              read_enable;
    logic              store_enable;
    logic [LANE_W-1:0] byte_lanes;
    logic [WORD_W-1:0] store_word;
    logic              branch_taken;
    logic              link_request;
    logic              overflow;
    logic              address_error;

    modport source (output valid, write_enable, write_value, effective_address,
                    read_enable, store_enable, byte_lanes, store_word, branch_taken,
                    link_request, overflow, address_error, input ready);
    modport sink   (input valid, write_enable, write_value, effective_address,
                    read_enable, store_enable, byte_lanes, store_word, branch_taken,
                    link_request, overflow, address_error, output ready);
endinterface

### hw/rtl/ite_exec.sv
// Combinational I-type execute logic: ALU, load extract/merge, store lanes, branches.
// Depends on ite_pkg.
module ite_exec (
    input  ite_pkg::instr_t  instr,
    output ite_pkg::result_t res
);
    import ite_pkg::*;

    logic [WORD_W-1:0] simm;
    logic [WORD_W-1:0] zimm;
    logic [WORD_W-1:0] addr;
    logic [1:0]        b;
    logic [WORD_W-1:0] rs;
    logic [WORD_W-1:0] rt;
    logic [WORD_W-1:0] mem;
    logic [WORD_W-1:0] sum;
    logic [7:0]        ld_byte;
    logic [HALF_W-1:0] ld_half;
    logic [WORD_W-1:0] lwl_word;
    logic [WORD_W-1:0] lwr_word;
    logic              rs_neg;
    logic              rs_zero;
    op_t               op;

    assign rs   = instr.base_value;
    assign rt   = instr.target_value;
    assign mem  = instr.memory_word;
    assign simm = {{(WORD_W-HALF_W){instr.immediate[HALF_W-1]}}, instr.immediate};
    assign zimm = {{(WORD_W-HALF_W){1'b0}}, instr.immediate};
    assign sum  = rs + simm;
    assign addr = sum;
    assign b    = addr[1:0];
    assign op   = op_t'(instr.operation);
    assign rs_neg  = rs[WORD_W-1];
    assign rs_zero = (rs == '0);

    // big-endian: byte offset 0 sits in bits 31:24
    always_comb
    begin
        case (b)
            2'd0:    ld_byte = mem[31:24];
            2'd1:    ld_byte = mem[23:16];
            2'd2:    ld_byte = mem[15:8];
            default: ld_byte = mem[7:0];
        endcase
        ld_half = b[1] ? mem[15:0] : mem[31:16];
        case (b)
            2'd0:    lwl_word = mem;
            2'd1:    lwl_word = {mem[23:0], rt[7:0]};
            2'd2:    lwl_word = {mem[15:0], rt[15:0]};
            default: lwl_word = {mem[7:0], rt[23:0]};
        endcase
        // loaded bytes start from zero; upper bytes come from rt only
        case (b)
            2'd0:    lwr_word = {rt[31:8], mem[31:24]};
            2'd1:    lwr_word = {rt[31:16], mem[31:16]};
            2'd2:    lwr_word = {rt[31:24], mem[31:8]};
            default: lwr_word = mem;
        endcase
    end

    always_comb
    begin
        res = '0;
        if (instr.operation >= OP_LW && instr.operation <= OP_SH)
        begin
            res.effective_address = addr;
        end
        case (op)
            OP_ADDI:
            begin
                if (rs_neg == simm[WORD_W-1] && sum[WORD_W-1] != rs_neg)
                begin
                    res.overflow = 1'b1;
                end
                else
                begin
                    res.write_enable = 1'b1;
                    res.write_value  = sum;
                end
            end
            OP_ADDIU:
            begin
                res.write_enable = 1'b1;
                res.write_value  = sum;
            end
            OP_ANDI:
            begin
                res.write_enable = 1'b1;
                res.write_value  = rs & zimm;
            end
            OP_ORI:
            begin
                res.write_enable = 1'b1;
                res.write_value  = rs | zimm;
            end
            OP_XORI:
            begin
                res.write_enable = 1'b1;
                res.write_value  = rs ^ zimm;
            end
            OP_SLTI:
            begin
                res.write_enable = 1'b1;
                res.write_value  = {{(WORD_W-1){1'b0}}, ($signed(rs) < $signed(simm))};
            end
            OP_SLTIU:
            begin
                res.write_enable = 1'b1;
                res.write_value  = {{(WORD_W-1){1'b0}}, (rs < simm)};
            end
            OP_LUI:
            begin
                res.write_enable = 1'b1;
                res.write_value  = zimm << HALF_SHIFT;
            end
            OP_LW:
            begin
                if (b != 2'd0)
                begin
                    res.address_error = 1'b1;
                end
                else
                begin
                    res.read_enable  = 1'b1;
                    res.write_enable = 1'b1;
                    res.write_value  = mem;
                end
            end
            OP_LB:
            begin
                res.read_enable  = 1'b1;
                res.write_enable = 1'b1;
                res.write_value  = {{(WORD_W-8){ld_byte[7]}}, ld_byte};
            end
            OP_LBU:
            begin
                res.read_enable  = 1'b1;
                res.write_enable = 1'b1;
                res.write_value  = {{(WORD_W-8){1'b0}}, ld_byte};
            end
            OP_LH, OP_LHU:
            begin
                if (b[0])
                begin
                    res.address_error = 1'b1;
                end
                else
                begin
                    res.read_enable  = 1'b1;
                    res.write_enable = 1'b1;
                    res.write_value  = {{(WORD_W-HALF_W){(op == OP_LH) & ld_half[HALF_W-1]}},
                                        ld_half};
                end
            end
            OP_LWL:
            begin
                res.read_enable  = 1'b1;
                res.write_enable = 1'b1;
                res.write_value  = lwl_word;
            end
            OP_LWR:
            begin
                res.read_enable  = 1'b1;
                res.write_enable = 1'b1;
                res.write_value  = lwr_word;
            end
            OP_SW:
            begin
                if (b != 2'd0)
                begin
                    res.address_error = 1'b1;
                end
                else
                begin
                    res.store_enable = 1'b1;
                    res.byte_lanes   = 4'b1111;
                    res.store_word   = rt;
                end
            end
            OP_SB:
            begin
                res.store_enable = 1'b1;
                res.byte_lanes   = 4'b1000 >> b;
                // shift by 8*(3-b); 3-b is ~b on two bits
                res.store_word   = {{(WORD_W-8){1'b0}}, rt[7:0]} << {~b, 3'b000};
            end
            OP_SH:
            begin
                if (b[0])
                begin
                    res.address_error = 1'b1;
                end
                else
                begin
                    res.store_enable = 1'b1;
                    res.byte_lanes   = b[1] ? 4'b0011 : 4'b1100;
                    res.store_word   = b[1] ? {{HALF_W{1'b0}}, rt[HALF_W-1:0]}
                                            : {rt[HALF_W-1:0], {HALF_W{1'b0}}};
                end
            end
            OP_BEQ:  res.branch_taken = (rs == rt);
            OP_BNE:  res.branch_taken = (rs != rt);
            OP_BGEZ: res.branch_taken = !rs_neg;
            OP_BGTZ: res.branch_taken = !rs_neg && !rs_zero;
            OP_BLEZ: res.branch_taken = rs_neg || rs_zero;
            OP_BLTZ: res.branch_taken = rs_neg;
            OP_BGEZAL:
            begin
                res.branch_taken = !rs_neg;
                res.link_request = 1'b1;
            end
            OP_BLTZAL:
            begin
                res.branch_taken = rs_neg;
                res.link_request = 1'b1;
            end
            default: res = '0;
        endcase
    end

endmodule

### hw/rtl/ite_result_reg.sv
// Result register with valid/ready handshake toward the consumer.
// Depends on ite_pkg and ite_result_if.
module ite_result_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    input  ite_pkg::result_t  item,
    output logic              ready,
    ite_result_if.source      result
);
    import ite_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t item_reg;

    // accept whenever the register is empty or being drained this cycle
    assign ready      = !valid_reg || result.ready;
    assign valid_next = ready ? valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && valid)
        begin
            item_reg <= item;
        end
    end

    assign result.valid             = valid_reg;
    assign result.write_enable      = item_reg.write_enable;
    assign result.write_value       = item_reg.write_value;
    assign result.effective_address = item_reg.effective_address;
    assign result.read_enable       = item_reg.read_enable;
    assign result.store_enable      = item_reg.store_enable;
    assign result.byte_lanes        = item_reg.byte_lanes;
    assign result.store_word        = item_reg.store_word;
    assign result.branch_taken      = item_reg.branch_taken;
    assign result.link_request      = item_reg.link_request;
    assign result.overflow          = item_reg.overflow;
    assign result.address_error     = item_reg.address_error;

endmodule

### hw/rtl/immediate_type_instruction_execute_top.sv
// I-type execute stage: one request per clock while the result side is not stalled.
// A request is captured in an input register, evaluated by a single combinational pass
// (adder, byte/halfword select, merge and compare logic), and held in a result register.
// Both registers advance together, so a new request is taken every cycle while the result
// side keeps up; a stalled result holds the pipe and the input side backs up one request.
// Depends on ite_pkg, ite_if, ite_exec, ite_result_reg and assert_macros.svh.
`include "assert_macros.svh"

module immediate_type_instruction_execute_top (
    input  logic         clk,
    input  logic         rst_n,
    ite_instr_if.sink    instr,
    ite_result_if.source result
);
    import ite_pkg::*;

    logic    in_valid_reg;
    logic    in_valid_next;
    instr_t  in_item_reg;
    result_t exec_res;
    logic    res_ready;

    assign instr.ready   = !in_valid_reg || res_ready;
    assign in_valid_next = instr.ready ? instr.valid : in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (instr.valid && instr.ready)
        begin
            in_item_reg.operation    <= instr.operation;
            in_item_reg.base_value   <= instr.base_value;
            in_item_reg.target_value <= instr.target_value;
            in_item_reg.immediate    <= instr.immediate;
            in_item_reg.memory_word  <= instr.memory_word;
        end
    end

    ite_exec u_exec (
        .instr (in_item_reg),
        .res   (exec_res)
    );

    ite_result_reg u_result_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (in_valid_reg),
        .item   (exec_res),
        .ready  (res_ready),
        .result (result)
    );

    `ITE_ASSERT(a_pipe_advance, (in_valid_reg && res_ready) |=> result.valid, "request lost between stages")
    `ITE_NEVER(a_ld_st_excl, result.valid && result.read_enable && result.store_enable, "load and store together")
    `ITE_ASSERT(a_fault_no_write, (result.valid && (result.address_error || result.overflow)) |-> (!result.write_enable && !result.read_enable && !result.store_enable), "write on faulting request")
    `ITE_ASSERT(a_idle_value_zero, (result.valid && !result.write_enable) |-> (result.write_value == '0), "stale write value")

endmodule
